### design/lsb_stego_extractor_defines.svh
// Assertion macros shared by the LSB steganography extractor RTL.
// Included by the modules that carry concurrent checks; depends on nothing.
`ifndef LSB_STEGO_EXTRACTOR_DEFINES_SVH
`define LSB_STEGO_EXTRACTOR_DEFINES_SVH
`ifndef ASSERT_OFF
`define LSE_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("lsb_stego_extractor check failed");
`define LSE_ASSERT_NORST(label, prop) \
	label: assert property (@(posedge clk) (prop)) \
		else $error("lsb_stego_extractor check failed");
`else
`define LSE_ASSERT(label, prop)
`define LSE_ASSERT_NORST(label, prop)
`endif
`endif

### design/lse_pkg.sv
// Package for the LSB steganography extractor: parser stage codes, result kinds,
// widths and the result struct passed from the parser to the top level. No dependencies.
`default_nettype none
package lse_pkg;

	localparam int DATA_W  = 8;
	localparam int KIND_W  = 3;
	localparam int STAGE_W = 3;
	localparam int CNT_W   = 4;
	localparam int WORD_W  = 32;
	localparam int CARR_W  = 2;

	localparam logic [WORD_W-1:0] MAGIC_RESET = 32'h6269_6D67;

	// Carriers that make one hidden byte.
	localparam logic [CNT_W-1:0] BYTE_CARRIERS = 4'd4;

	localparam logic [STAGE_W-1:0] ST_MAGIC   = 3'd0;
	localparam logic [STAGE_W-1:0] ST_NAMELEN = 3'd1;
	localparam logic [STAGE_W-1:0] ST_NAME    = 3'd2;
	localparam logic [STAGE_W-1:0] ST_PAYLEN  = 3'd3;
	localparam logic [STAGE_W-1:0] ST_PAYLOAD = 3'd4;
	localparam logic [STAGE_W-1:0] ST_DONE    = 3'd5;
	localparam logic [STAGE_W-1:0] ST_HALT    = 3'd6;

	localparam logic [KIND_W-1:0] KIND_NAME   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_DATA   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_DONE   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_BADMAG = 3'd3;
	localparam logic [KIND_W-1:0] KIND_NONAME = 3'd4;

	typedef struct packed {
		logic              hit;
		logic [DATA_W-1:0] data_byte;
		logic [KIND_W-1:0] kind;
		logic              last;
	} result_t;

endpackage
`default_nettype wire

### design/lse_parser.sv
// Parser state and its single-step update for the LSB steganography extractor.
// Depends on lse_pkg and the shared assertion macro header.
`default_nettype none
`include "lsb_stego_extractor_defines.svh"
module lse_parser (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  step_en,
	input  wire  [lse_pkg::CARR_W-1:0]           carrier,
	input  wire                                  first_of_image,
	input  wire  [lse_pkg::WORD_W-1:0]           magic_word,
	output lse_pkg::result_t                     res
);

	logic [lse_pkg::STAGE_W-1:0] stage_q, stage_nxt, b_stage;
	logic [lse_pkg::CNT_W-1:0]   cnt_q, cnt_nxt, b_cnt, sh_cnt;
	logic [lse_pkg::WORD_W-1:0]  buf_q, buf_nxt, b_buf, sh_buf;
	logic [lse_pkg::WORD_W-1:0]  rem_q, rem_nxt, b_rem, rem_dec;
	logic                        active, word_stage, unit_done, rem_last;

	always_comb begin
		// A new image restarts the parser before this byte is used.
		if (first_of_image) begin
			b_stage = lse_pkg::ST_MAGIC;
			b_cnt   = '0;
			b_buf   = '0;
			b_rem   = '0;
		end else begin
			b_stage = stage_q;
			b_cnt   = cnt_q;
			b_buf   = buf_q;
			b_rem   = rem_q;
		end

		active     = (b_stage == lse_pkg::ST_MAGIC) || (b_stage == lse_pkg::ST_NAMELEN) ||
			(b_stage == lse_pkg::ST_NAME) || (b_stage == lse_pkg::ST_PAYLEN) ||
			(b_stage == lse_pkg::ST_PAYLOAD);
		word_stage = (b_stage == lse_pkg::ST_MAGIC) || (b_stage == lse_pkg::ST_NAMELEN) ||
			(b_stage == lse_pkg::ST_PAYLEN);
		sh_buf     = {b_buf[lse_pkg::WORD_W-lse_pkg::CARR_W-1:0], carrier};
		sh_cnt     = b_cnt + 1'b1;
		// A word is complete when the count wraps after sixteen carriers.
		unit_done  = word_stage ? (sh_cnt == '0) : (sh_cnt == lse_pkg::BYTE_CARRIERS);
		rem_dec    = b_rem - 1'b1;
		rem_last   = (b_rem == {{(lse_pkg::WORD_W-1){1'b0}}, 1'b1});

		stage_nxt     = b_stage;
		cnt_nxt       = b_cnt;
		buf_nxt       = b_buf;
		rem_nxt       = b_rem;
		res.hit       = 1'b0;
		res.data_byte = '0;
		res.kind      = lse_pkg::KIND_NAME;
		res.last      = 1'b0;

		if (active) begin
			buf_nxt = sh_buf;
			cnt_nxt = sh_cnt;
			if (unit_done) begin
				buf_nxt = '0;
				cnt_nxt = '0;
				unique case (b_stage)
					lse_pkg::ST_MAGIC: begin
						if (sh_buf != magic_word) begin
							stage_nxt = lse_pkg::ST_HALT;
							res.hit   = 1'b1;
							res.kind  = lse_pkg::KIND_BADMAG;
						end else begin
							stage_nxt = lse_pkg::ST_NAMELEN;
						end
					end
					lse_pkg::ST_NAMELEN: begin
						if (sh_buf == '0) begin
							stage_nxt = lse_pkg::ST_HALT;
							res.hit   = 1'b1;
							res.kind  = lse_pkg::KIND_NONAME;
						end else begin
							rem_nxt   = sh_buf;
							stage_nxt = lse_pkg::ST_NAME;
						end
					end
					lse_pkg::ST_NAME: begin
						rem_nxt       = rem_dec;
						if (rem_last)
							stage_nxt = lse_pkg::ST_PAYLEN;
						res.hit       = 1'b1;
						res.data_byte = sh_buf[lse_pkg::DATA_W-1:0];
						res.kind      = lse_pkg::KIND_NAME;
					end
					lse_pkg::ST_PAYLEN: begin
						if (sh_buf == '0) begin
							stage_nxt = lse_pkg::ST_DONE;
							res.hit   = 1'b1;
							res.kind  = lse_pkg::KIND_DONE;
							res.last  = 1'b1;
						end else begin
							rem_nxt   = sh_buf;
							stage_nxt = lse_pkg::ST_PAYLOAD;
						end
					end
					lse_pkg::ST_PAYLOAD: begin
						rem_nxt       = rem_dec;
						if (rem_last)
							stage_nxt = lse_pkg::ST_DONE;
						res.hit       = 1'b1;
						res.data_byte = sh_buf[lse_pkg::DATA_W-1:0];
						res.kind      = lse_pkg::KIND_DATA;
						res.last      = rem_last;
					end
					default: begin
						stage_nxt = b_stage;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= lse_pkg::ST_MAGIC;
			cnt_q   <= '0;
			buf_q   <= '0;
			rem_q   <= '0;
		end else if (step_en) begin
			stage_q <= stage_nxt;
			cnt_q   <= cnt_nxt;
			buf_q   <= buf_nxt;
			rem_q   <= rem_nxt;
		end
	end

	`LSE_ASSERT(a_byte_count_short,
		((stage_q == lse_pkg::ST_NAME) || (stage_q == lse_pkg::ST_PAYLOAD)) |->
		(cnt_q < lse_pkg::BYTE_CARRIERS))
	`LSE_ASSERT(a_remaining_nonzero,
		((stage_q == lse_pkg::ST_NAME) || (stage_q == lse_pkg::ST_PAYLOAD)) |->
		(rem_q != '0))
	`LSE_ASSERT_NORST(a_empty_buffer, (cnt_q == '0) |-> (buf_q == '0))

endmodule
`default_nettype wire

### design/lsb_stego_extractor.sv
// LSB steganography extractor: a result is held in the output register after its input
// is accepted; one input transaction can be accepted every cycle unless the output stalls.
// The parser step sits between the input register and the result register, so the
// sustained rate is one container byte per clock while the result side keeps up.
// Asynchronous active-low reset empties both registers, sets the parser to expect the
// magic word and loads the signature register with "bimg".
`default_nettype none
`include "lsb_stego_extractor_defines.svh"
module lsb_stego_extractor (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_wr_en,
	input  wire  [lse_pkg::WORD_W-1:0]   cfg_wr_data,   // magic_word
	input  wire                          s_axis_tvalid,
	output logic                         s_axis_tready,
	input  wire  [lse_pkg::DATA_W-1:0]   s_axis_tdata,  // [7:0] container_byte
	input  wire                          s_axis_tuser,  // [0] first_of_image
	output logic                         m_axis_tvalid,
	input  wire                          m_axis_tready,
	output logic [lse_pkg::DATA_W-1:0]   m_axis_tdata,  // [7:0] data_byte
	output logic [lse_pkg::KIND_W-1:0]   m_axis_tuser,  // [2:0] kind
	output logic                         m_axis_tlast   // last
);

	logic [lse_pkg::WORD_W-1:0] magic_q;
	logic                       valid_s1;
	logic [lse_pkg::CARR_W-1:0] carrier_s1;
	logic                       first_s1;
	logic                       out_valid_q;
	logic [lse_pkg::DATA_W-1:0] out_data_q;
	logic [lse_pkg::KIND_W-1:0] out_kind_q;
	logic                       out_last_q;
	logic                       step_go;
	lse_pkg::result_t           res;

	// A step that yields no result never waits on the output side.
	assign step_go       = valid_s1 && (!res.hit || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || step_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			magic_q <= lse_pkg::MAGIC_RESET;
		else if (cfg_wr_en)
			magic_q <= cfg_wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_axis_tready)
			valid_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			carrier_s1 <= s_axis_tdata[lse_pkg::CARR_W-1:0];
			first_s1   <= s_axis_tuser;
		end
	end

	lse_parser u_parser (
		.clk            (clk),
		.arst_n         (arst_n),
		.step_en        (step_go),
		.carrier        (carrier_s1),
		.first_of_image (first_s1),
		.magic_word     (magic_q),
		.res            (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (step_go && res.hit)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (step_go && res.hit) begin
			out_data_q <= res.data_byte;
			out_kind_q <= res.kind;
			out_last_q <= res.last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;

	`LSE_ASSERT(a_no_overwrite,
		(step_go && res.hit) |-> (!out_valid_q || m_axis_tready))
	`LSE_ASSERT(a_load_sets_valid, $past(step_go && res.hit) |-> out_valid_q)

endmodule
`default_nettype wire
